>>> rtl/core/hrlp_pkg.sv
// Shared types, constants and lookup function of the HTTP request line parser.
package hrlp_pkg;

   // Queue depth between the front and back parts, and of the result queue.
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_LIMIT = 1'b0;
   localparam logic [15:0] LIMIT_RESET = 16'd8190;

   // Result codes.
   localparam logic [1:0] DEST_NONE    = 2'd0;
   localparam logic [1:0] DEST_METHOD  = 2'd1;
   localparam logic [1:0] DEST_URI     = 2'd2;
   localparam logic [1:0] DEST_VERSION = 2'd3;

   localparam logic [1:0] STATUS_PARTIAL = 2'd0;
   localparam logic [1:0] STATUS_GOOD    = 2'd1;
   localparam logic [1:0] STATUS_BAD     = 2'd2;

   localparam logic ACTION_FEED  = 1'b0;
   localparam logic ACTION_CLEAR = 1'b1;

   // State numbers used inside the transition table entries.
   localparam logic [4:0] TST_BAD     = 5'd0;
   localparam logic [4:0] TST_METHOD  = 5'd2;
   localparam logic [4:0] TST_SEP     = 5'd3;
   localparam logic [4:0] TST_STAR    = 5'd4;
   localparam logic [4:0] TST_PATH    = 5'd5;
   localparam logic [4:0] TST_VERSION = 5'd6;

   // Tag bits of a transition table entry.
   localparam logic [2:0] TAG_METHOD = 3'b001;
   localparam logic [2:0] TAG_URI    = 3'b010;

   localparam logic [3:0] CLASS_INVALID = 4'd0;
   localparam logic [3:0] CLASS_COUNT   = 4'd7;

   // Character classes for codes 0..127, eight nibbles per word, first code on top.
   localparam logic [31:0] CLASS_WORDS [0:15] = '{
      32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
      32'h61021111, 32'h33413115, 32'h11111111, 32'h11330303,
      32'h31111111, 32'h11111111, 32'h11111111, 32'h11100021,
      32'h21111111, 32'h11111111, 32'h11111111, 32'h11102010
   };

   // Transitions for table rows 1..5 (start, method, separator, star, path) by class.
   localparam logic [7:0] TRANS_TABLE [0:5][0:6] = '{
      '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h00, 8'h22, 8'h22, 8'h00, 8'h22, 8'h00, 8'h00},
      '{8'h00, 8'h22, 8'h22, 8'h00, 8'h22, 8'h00, 8'h03},
      '{8'h00, 8'h00, 8'h00, 8'h00, 8'h44, 8'h45, 8'h00},
      '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h06},
      '{8'h00, 8'h45, 8'h00, 8'h45, 8'h45, 8'h45, 8'h06}
   };

   localparam logic [2:0] ROW_NONE   = 3'd0;
   localparam logic [2:0] ROW_START  = 3'd1;
   localparam logic [2:0] ROW_METHOD = 3'd2;
   localparam logic [2:0] ROW_SEP    = 3'd3;
   localparam logic [2:0] ROW_STAR   = 3'd4;
   localparam logic [2:0] ROW_PATH   = 3'd5;

   // Version text; a '1' stands for any decimal digit.
   localparam int VER_LEN = 10;
   localparam int VER_IDX_W = $clog2(VER_LEN);
   localparam logic [7:0] VERSION_TEXT [0:VER_LEN-1] = '{
      8'h48, 8'h54, 8'h54, 8'h50, 8'h2f, 8'h31, 8'h2e, 8'h31, 8'h0d, 8'h0a
   };
   localparam logic [7:0] CHAR_ANY_DIGIT = 8'h31;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_NINE      = 8'h39;

   typedef enum logic [7:0] {
      PH_BAD     = 8'b0000_0001,
      PH_START   = 8'b0000_0010,
      PH_METHOD  = 8'b0000_0100,
      PH_SEP     = 8'b0000_1000,
      PH_STAR    = 8'b0001_0000,
      PH_PATH    = 8'b0010_0000,
      PH_VERSION = 8'b0100_0000,
      PH_GOOD    = 8'b1000_0000
   } phase_type;

   // One classified item on its way from the front to the back.
   typedef struct packed {
      logic       action;
      logic [7:0] octet;
      logic [3:0] byte_class;
      logic       is_digit;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } link_type;

   typedef struct packed {
      logic [1:0] byte_dest;
      logic [7:0] byte_value;
      logic [1:0] parse_status;
   } result_type;

   function automatic logic [3:0] class_of(input logic [7:0] octet);
      logic [31:0] word;
      logic [4:0]  shift;
      begin
         word  = CLASS_WORDS[octet[6:3]];
         shift = {~octet[2:0], 2'b00};
         if (octet[7]) begin
            class_of = CLASS_INVALID;
         end else begin
            class_of = word[shift +: 4];
         end
      end
   endfunction

endpackage

>>> rtl/core/http_request_line_parser_top.sv
// Top level of the HTTP request line parser with its configuration register.
//
// The parser checks an HTTP request line of the form METHOD SP ("*" | path)
// SP "HTTP/d.d" CR LF, one byte per transfer on the request queue, and
// returns exactly one result per request transfer on the response queue:
// where the byte belongs (method, URI, version or nowhere), the byte itself
// when it is tagged, and the status of the line after it (partial, good or
// bad). A request with action set clears the parse and restarts it. Once a
// line is good or bad, further bytes are answered with the current status and
// change nothing until a clear. The register line_byte_limit (byte address 0,
// reset 8190) bounds the bytes in one line; the byte that goes past it makes
// the line bad. The block takes one byte per clock cycle with no bubbles
// while the response side keeps popping; each byte is registered in the
// front queue, and the back state machine turns it into a result that is
// registered in the result queue. Both queues hold two entries, so either
// side may stall while the other keeps going until the queues fill. Write the
// register only while no byte is in flight.
module http_request_line_parser_top
   import hrlp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Request queue.
   input  logic                  push,
   output logic                  full,
   input  logic                  req_action,
   input  logic [7:0]            req_octet,
   // Response queue.
   output logic                  empty,
   input  logic                  pop,
   output logic [1:0]            rsp_byte_dest,
   output logic [7:0]            rsp_byte_value,
   output logic [1:0]            rsp_parse_status,
   // Configuration port.
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [15:0] limit_ff, limit_in;
   logic        reg_index;
   logic        wr_strobe;
   link_type    link;
   logic        take;
   result_type  result;

   // The register index is the word address; addresses past the list are
   // accepted and ignored, and read back as zero.
   assign reg_index = paddr[2];
   assign pready    = 1'b1;
   assign wr_strobe = psel && penable && pwrite && pready;

   always_comb begin
      limit_in = limit_ff;
      if (wr_strobe && reg_index == CSR_IDX_LIMIT) begin
         limit_in = pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   assign prdata = (reg_index == CSR_IDX_LIMIT) ? {16'd0, limit_ff} : '0;

   // The front classifies each byte through the class table and queues it.
   hrlp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_action (req_action),
      .req_octet  (req_octet),
      .link       (link),
      .take       (take)
   );

   // The back runs the line state machine and queues the results.
   hrlp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .line_byte_limit (limit_ff),
      .link            (link),
      .take            (take),
      .pop             (pop),
      .empty           (empty),
      .result          (result)
   );

   assign rsp_byte_dest    = result.byte_dest;
   assign rsp_byte_value   = result.byte_value;
   assign rsp_parse_status = result.parse_status;

endmodule

>>> rtl/core/hrlp_front.sv
// Front part: classifies incoming bytes and queues them for the back part.
module hrlp_front
   import hrlp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic       req_action,
   input  logic [7:0] req_octet,
   output link_type   link,
   input  logic       take
);

   item_type             entry_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;
   item_type             new_item;
   logic                 do_push;
   logic                 do_pop;

   always_comb begin
      new_item.action     = req_action;
      new_item.octet      = req_octet;
      new_item.byte_class = class_of(req_octet);
      new_item.is_digit   = (req_octet >= CHAR_ZERO) && (req_octet <= CHAR_NINE);
   end

   assign full    = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign do_push = push && !full;
   assign do_pop  = take && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

   assign link.valid = (count_ff != '0);
   assign link.item  = entry_ff[rd_ptr_ff];

`ifndef NO_ASSERTIONS
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= Q_CNT_W'(Q_DEPTH))
      else $error("front queue count beyond its depth");
`endif

endmodule

>>> rtl/core/hrlp_back.sv
// Back part: runs the request line state machine and queues the results.
module hrlp_back
   import hrlp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [15:0] line_byte_limit,
   input  link_type    link,
   output logic        take,
   input  logic        pop,
   output logic        empty,
   output result_type  result
);

   phase_type               phase_ff, phase_in;
   logic [VER_IDX_W-1:0]    vidx_ff, vidx_in;
   logic [15:0]             count_ff, count_in;
   logic [16:0]             next_count;
   logic                    over_limit;
   logic [2:0]              row;
   logic [7:0]              trans;
   logic [7:0]              expect_char;
   logic                    char_ok;
   logic [1:0]              dest;
   result_type              new_result;

   result_type              out_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]      out_cnt_ff, out_cnt_in;
   logic                    out_full;
   logic                    do_pop;

   function automatic phase_type phase_of(input logic [4:0] code);
      begin
         unique case (code)
            TST_METHOD:  phase_of = PH_METHOD;
            TST_SEP:     phase_of = PH_SEP;
            TST_STAR:    phase_of = PH_STAR;
            TST_PATH:    phase_of = PH_PATH;
            TST_VERSION: phase_of = PH_VERSION;
            default:     phase_of = PH_BAD;
         endcase
      end
   endfunction

   assign out_full = (out_cnt_ff == Q_CNT_W'(Q_DEPTH));
   assign take     = link.valid && !out_full;

   assign next_count  = {1'b0, count_ff} + 17'd1;
   assign over_limit  = next_count > {1'b0, line_byte_limit};
   assign expect_char = VERSION_TEXT[vidx_ff];
   assign char_ok     = (expect_char == CHAR_ANY_DIGIT) ? link.item.is_digit
                                                        : (link.item.octet == expect_char);

   always_comb begin
      unique case (phase_ff)
         PH_START:  row = ROW_START;
         PH_METHOD: row = ROW_METHOD;
         PH_SEP:    row = ROW_SEP;
         PH_STAR:   row = ROW_STAR;
         PH_PATH:   row = ROW_PATH;
         default:   row = ROW_NONE;
      endcase
      if (link.item.byte_class < CLASS_COUNT) begin
         trans = TRANS_TABLE[row][link.item.byte_class[2:0]];
      end else begin
         trans = '0;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      vidx_in  = vidx_ff;
      count_in = count_ff;
      dest     = DEST_NONE;
      if (take) begin
         if (link.item.action == ACTION_CLEAR) begin
            phase_in = PH_START;
            vidx_in  = '0;
            count_in = '0;
         end else if (phase_ff != PH_GOOD && phase_ff != PH_BAD) begin
            count_in = next_count[15:0];
            if (over_limit) begin
               phase_in = PH_BAD;
            end else if (phase_ff == PH_VERSION) begin
               if (!char_ok) begin
                  phase_in = PH_BAD;
               end else if (vidx_ff == VER_IDX_W'(VER_LEN - 1)) begin
                  phase_in = PH_GOOD;
               end else begin
                  vidx_in = vidx_ff + 1'b1;
               end
               if (expect_char > CHAR_SPACE) begin
                  dest = DEST_VERSION;
               end
            end else begin
               if (link.item.byte_class == CLASS_INVALID) begin
                  phase_in = PH_BAD;
               end else begin
                  phase_in = phase_of(trans[4:0]);
               end
               vidx_in = '0;
               if (trans[7:5] == TAG_METHOD) begin
                  dest = DEST_METHOD;
               end else if (trans[7:5] == TAG_URI) begin
                  dest = DEST_URI;
               end
            end
         end
      end
   end

   always_comb begin
      new_result.byte_dest  = dest;
      new_result.byte_value = (dest != DEST_NONE) ? link.item.octet : 8'd0;
      if (phase_in == PH_GOOD) begin
         new_result.parse_status = STATUS_GOOD;
      end else if (phase_in == PH_BAD) begin
         new_result.parse_status = STATUS_BAD;
      end else begin
         new_result.parse_status = STATUS_PARTIAL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         vidx_ff  <= '0;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         vidx_ff  <= vidx_in;
         count_ff <= count_in;
      end
   end

   // Result queue.
   assign do_pop = pop && (out_cnt_ff != '0);
   assign empty  = (out_cnt_ff == '0);
   assign result = out_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      out_cnt_in = out_cnt_ff;
      if (take) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (take && !do_pop) begin
         out_cnt_in = out_cnt_ff + 1'b1;
      end else if (do_pop && !take) begin
         out_cnt_in = out_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         out_cnt_ff <= '0;
      end else begin
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         out_cnt_ff <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_ff[wr_ptr_ff] <= new_result;
      end
   end

`ifndef NO_ASSERTIONS
   a_clear_restarts: assert property (@(posedge clock) disable iff (reset)
      (take && link.item.action == ACTION_CLEAR) |=> (phase_ff == PH_START && count_ff == '0))
      else $error("clear did not restart the parse");
   a_good_holds: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_GOOD && !(take && link.item.action == ACTION_CLEAR))
      |=> phase_ff == PH_GOOD)
      else $error("completed line left the good state without a clear");
   a_done_count_frozen: assert property (@(posedge clock) disable iff (reset)
      ((phase_ff == PH_GOOD || phase_ff == PH_BAD) && !(take && link.item.action == ACTION_CLEAR))
      |=> count_ff == $past(count_ff))
      else $error("byte count moved after the line was finished");
`endif

endmodule

>>> tb/tb.sv
// Self-checking testbench for the HTTP request line parser top level.
`timescale 1ns / 100ps

module tb;
   import hrlp_pkg::*;

   // Parse states of the line checker, as the predictor numbers them.
   localparam logic [4:0] PS_BAD           = 5'd0;
   localparam logic [4:0] PS_START         = 5'd1;
   localparam logic [4:0] PS_VERSION_FIRST = 5'd6;
   localparam logic [4:0] PS_VERSION_LAST  = 5'd15;
   localparam logic [4:0] PS_GOOD          = 5'd16;

   localparam logic [7:0] CR = 8'h0d;
   localparam logic [7:0] LF = 8'h0a;
   localparam logic [7:0] ANY_DIGIT = "1";

   localparam logic [CSR_ADDR_W-1:0] LIMIT_ADDR = {CSR_IDX_LIMIT, 2'b00};
   localparam int QUIET_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 10;

   // Character classes for codes 0..127, eight nibbles per word, first code on top.
   localparam logic [31:0] CLASS_NIBBLES [0:15] = '{
      32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
      32'h61021111, 32'h33413115, 32'h11111111, 32'h11330303,
      32'h31111111, 32'h11111111, 32'h11111111, 32'h11100021,
      32'h21111111, 32'h11111111, 32'h11111111, 32'h11102010
   };

   // Next state in the low five bits; bits 7:5 say whether the byte is method or URI.
   localparam logic [7:0] STEP_TABLE [1:5][0:6] = '{
      '{8'h00, 8'h22, 8'h22, 8'h00, 8'h22, 8'h00, 8'h00},
      '{8'h00, 8'h22, 8'h22, 8'h00, 8'h22, 8'h00, 8'h03},
      '{8'h00, 8'h00, 8'h00, 8'h00, 8'h44, 8'h45, 8'h00},
      '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h06},
      '{8'h00, 8'h45, 8'h00, 8'h45, 8'h45, 8'h45, 8'h06}
   };
   localparam logic [2:0] MARK_METHOD = 3'b001;
   localparam logic [2:0] MARK_URI    = 3'b010;

   localparam logic [7:0] VERSION_CHARS [0:9] = '{
      "H", "T", "T", "P", "/", "1", ".", "1", 8'h0d, 8'h0a
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic full;
   logic req_action = ACTION_FEED;
   logic [7:0] req_octet = 8'h00;
   logic empty;
   logic pop = 1'b0;
   logic [1:0] rsp_byte_dest;
   logic [7:0] rsp_byte_value;
   logic [1:0] rsp_parse_status;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   // Predictor state: a private copy of the parse state, byte count and limit.
   logic [4:0] parse_state = PS_START;
   logic [15:0] line_count = 16'd0;
   logic [15:0] line_limit = LIMIT_RESET;

   result_type expected_tags [$];
   int mismatch_count = 0;
   int bytes_fed = 0;
   int quiet_cycles = 0;
   bit full_rate = 1'b0;
   int rsp_hold_request = 0;

   http_request_line_parser_top dut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_action       (req_action),
      .req_octet        (req_octet),
      .empty            (empty),
      .pop              (pop),
      .rsp_byte_dest    (rsp_byte_dest),
      .rsp_byte_value   (rsp_byte_value),
      .rsp_parse_status (rsp_parse_status),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Looks up the 4-bit class of a byte; codes with the top bit set are invalid.
   function automatic logic [3:0] octet_class(input logic [7:0] b);
      logic [31:0] word;
      int sh;
      word = CLASS_NIBBLES[b[6:3]];
      sh = (7 - int'(b[2:0])) * 4;
      if (b[7]) begin
         return CLASS_INVALID;
      end
      return word[sh +: 4];
   endfunction

   // Advances the predicted parse by one request transfer and returns the tag it earns.
   function automatic result_type predict_parse(input logic act, input logic [7:0] b);
      result_type r;
      logic [16:0] next_count;
      logic [3:0] cls;
      logic [7:0] step;
      logic [7:0] want;
      logic match;
      r.byte_dest = DEST_NONE;
      if (act == ACTION_CLEAR) begin
         parse_state = PS_START;
         line_count = 16'd0;
      end else if (parse_state >= PS_START && parse_state <= PS_VERSION_LAST) begin
         next_count = {1'b0, line_count} + 17'd1;
         line_count = next_count[15:0];
         if (next_count > {1'b0, line_limit}) begin
            parse_state = PS_BAD;
         end else if (parse_state < PS_VERSION_FIRST) begin
            cls = octet_class(b);
            step = (cls < CLASS_COUNT) ? STEP_TABLE[parse_state][cls] : 8'h00;
            parse_state = (cls == CLASS_INVALID) ? PS_BAD : step[4:0];
            if (step[7:5] == MARK_METHOD) begin
               r.byte_dest = DEST_METHOD;
            end else if (step[7:5] == MARK_URI) begin
               r.byte_dest = DEST_URI;
            end
         end else begin
            want = VERSION_CHARS[parse_state - PS_VERSION_FIRST];
            match = (want == ANY_DIGIT) ? (b >= "0" && b <= "9") : (b == want);
            parse_state = match ? parse_state + 5'd1 : PS_BAD;
            // CR and LF are checked but never tagged as version bytes.
            if (want > " ") begin
               r.byte_dest = DEST_VERSION;
            end
         end
      end
      r.byte_value = (r.byte_dest != DEST_NONE) ? b : 8'h00;
      if (parse_state == PS_GOOD) begin
         r.parse_status = STATUS_GOOD;
      end else if (parse_state == PS_BAD || parse_state > PS_GOOD) begin
         r.parse_status = STATUS_BAD;
      end else begin
         r.parse_status = STATUS_PARTIAL;
      end
      return r;
   endfunction

   // Offers one request and waits for its transfer, idling first at random.
   task automatic send_byte(input logic act, input logic [7:0] b);
      while (!full_rate && $urandom_range(99) < 27) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_action <= act;
      req_octet <= b;
      @(posedge clock);
      while (full) begin
         @(posedge clock);
      end
      expected_tags.insert(expected_tags.size(), predict_parse(act, b));
      bytes_fed++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_byte(ACTION_FEED, s[i]);
      end
   endtask

   // Feeds one byte of a line; now and then a clear goes before it, or the byte is replaced by noise.
   task automatic send_line_byte(input logic [7:0] b, input int noise_pct);
      if ($urandom_range(199) < 3) begin
         send_byte(ACTION_CLEAR, 8'($urandom));
      end
      if ($urandom_range(99) < noise_pct) begin
         send_byte(ACTION_FEED, 8'($urandom_range(255)));
      end else begin
         send_byte(ACTION_FEED, b);
      end
   endtask

   // A request line with random method, target and version digits; noise and clears may spoil it.
   task automatic send_random_line(input int noise_pct);
      int n;
      send_byte(ACTION_CLEAR, 8'($urandom));
      n = $urandom_range(6, 1);
      for (int i = 0; i < n; i++) begin
         send_line_byte(8'($urandom_range("Z", "A")), noise_pct);
      end
      send_line_byte(" ", noise_pct);
      if ($urandom_range(4) == 0) begin
         send_line_byte("*", noise_pct);
      end else begin
         send_line_byte("/", noise_pct);
         n = $urandom_range(8);
         for (int i = 0; i < n; i++) begin
            send_line_byte(8'($urandom_range(8'h7e, 8'h21)), noise_pct);
         end
      end
      send_line_byte(" ", noise_pct);
      send_line_byte("H", noise_pct);
      send_line_byte("T", noise_pct);
      send_line_byte("T", noise_pct);
      send_line_byte("P", noise_pct);
      send_line_byte("/", noise_pct);
      send_line_byte(8'($urandom_range("9", "0")), noise_pct);
      send_line_byte(".", noise_pct);
      send_line_byte(8'($urandom_range("9", "0")), noise_pct);
      send_line_byte(CR, noise_pct);
      send_line_byte(LF, noise_pct);
      // Bytes after the end of the line should be answered and ignored.
      n = $urandom_range(2);
      for (int i = 0; i < n; i++) begin
         send_byte(ACTION_FEED, 8'($urandom));
      end
   endtask

   // Stops offering and waits until every expected response has been checked.
   task automatic wait_idle();
      push <= 1'b0;
      while (expected_tags.size() != 0) begin
         @(posedge clock);
      end
      // Every request yields a response, so the queues are empty by now and this wait is only margin.
      repeat (4) @(posedge clock);
   endtask

   // Writes the byte limit, then reads it back through the same port.
   task automatic write_limit(input logic [15:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= LIMIT_ADDR;
      pwdata <= {16'h0000, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      line_limit = value;
      @(posedge clock);
      psel <= 1'b1;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== {16'h0000, value}) begin
         $error("line_byte_limit readback: expected %0d, actual %0d", value, prdata);
         mismatch_count++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // A line with a star target, a version that tests any digit, then an ignored byte.
   task automatic test_good_line();
      send_byte(ACTION_CLEAR, 8'hff);
      send_text("G * HTTP/9.0");
      send_byte(ACTION_FEED, CR);
      send_byte(ACTION_FEED, LF);
      send_byte(ACTION_FEED, 8'hff);
   endtask

   // A byte of the top half is invalid at the start; the next byte is ignored.
   task automatic test_invalid_byte();
      send_byte(ACTION_CLEAR, 8'h00);
      send_byte(ACTION_FEED, 8'h80);
      send_byte(ACTION_FEED, 8'h00);
   endtask

   // The version byte is still tagged and echoed although it fails the match.
   task automatic test_version_mismatch();
      send_byte(ACTION_CLEAR, 8'h55);
      send_text("A / X");
   endtask

   // With a limit of one, the second byte of the line goes over it.
   task automatic test_line_limit();
      wait_idle();
      write_limit(16'd1);
      send_byte(ACTION_CLEAR, 8'h00);
      send_text("AB");
      wait_idle();
      write_limit(16'd65534);
   endtask

   // The receiver stops for a long stretch while lines keep coming, so the queues fill.
   task automatic test_backpressure();
      rsp_hold_request = 300;
      send_random_line(0);
      send_random_line(0);
   endtask

   // Random lines under one limit until the request count reaches the target.
   task automatic test_random_lines(input logic [15:0] limit, input int target,
                                    input bit steady);
      wait_idle();
      write_limit(limit);
      full_rate = steady;
      while (bytes_fed < target) begin
         send_random_line(3);
      end
      full_rate = 1'b0;
   endtask

   // Response side: checks each response transfer and drives pop, with random stalls.
   initial begin
      int hold_left;
      result_type want;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && pop && !empty) begin
            if (expected_tags.size() == 0) begin
               $error("response with no request waiting: dest %0d value %0h status %0d",
                      rsp_byte_dest, rsp_byte_value, rsp_parse_status);
               mismatch_count++;
            end else begin
               want = expected_tags.pop_front();
               if (rsp_byte_dest !== want.byte_dest) begin
                  $error("byte_dest: expected %0d, actual %0d", want.byte_dest, rsp_byte_dest);
                  mismatch_count++;
               end
               if (rsp_byte_value !== want.byte_value) begin
                  $error("byte_value: expected %0h, actual %0h", want.byte_value,
                         rsp_byte_value);
                  mismatch_count++;
               end
               if (rsp_parse_status !== want.parse_status) begin
                  $error("parse_status: expected %0d, actual %0d", want.parse_status,
                         rsp_parse_status);
                  mismatch_count++;
               end
            end
         end
         if (rsp_hold_request > 0) begin
            hold_left = rsp_hold_request;
            rsp_hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else begin
            pop <= full_rate || ($urandom_range(99) >= 27);
         end
      end
   end

   // Watchdog: the run is stuck if no transfer happens on either queue for too long.
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("http_request_line_parser_top verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_good_line();
      test_invalid_byte();
      test_version_mismatch();
      test_line_limit();
      test_backpressure();
      test_random_lines(LIMIT_RESET, 400, 1'b0);
      // A tight limit makes long lines go bad partway through.
      test_random_lines(16'($urandom_range(40, 10)), 700, 1'b0);
      test_random_lines(16'd65534, 1000, 1'b1);
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_tags.size() == 0) begin
         $display("http_request_line_parser_top verification clean");
      end else begin
         $display("http_request_line_parser_top verification failed");
      end
      $finish;
   end

endmodule
